@@ sv/aotr_pkg.sv @@
// Shared types, constants and float compare helpers for the outcode reject core.
package aotr_pkg;

  localparam int MAX_VERTS   = 512;
  localparam int VSLOT_W     = $clog2(MAX_VERTS);
  localparam int RING_CAP    = 8192;
  localparam int HIT_W       = $clog2(RING_CAP);
  localparam int FILL_W      = 14;
  localparam int INDEX_SPACE = 65536;
  localparam int IDX_W       = $clog2(INDEX_SPACE);
  localparam int EPOCH_W     = 4;
  localparam int CODE_W      = 6;
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] VisitedFlag = 8'h80;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_TRI    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X      = 3'd0,
    REG_MIN_Y      = 3'd1,
    REG_MIN_Z      = 3'd2,
    REG_MAX_X      = 3'd3,
    REG_MAX_Y      = 3'd4,
    REG_MAX_Z      = 3'd5,
    REG_MASK       = 3'd6,
    REG_FILL_START = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRI_B,
    ST_TRI_C
  } state_e;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
  } box_t;

  // Unsigned key whose order matches float order (non-NaN only).
  function automatic logic [31:0] order_key(logic [31:0] a);
    logic [31:0] v;
    v = (a == 32'h8000_0000) ? 32'h0 : a;
    order_key = v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  // Ordered a >= b, false on any NaN.
  function automatic logic fge(logic [31:0] a, logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = a[30:0] > 31'h7F80_0000;
    nan_b = b[30:0] > 31'h7F80_0000;
    fge = !nan_a && !nan_b && (order_key(a) >= order_key(b));
  endfunction

endpackage

@@ sv/aotr_classify.sv @@
// Six-way box compare producing a vertex outcode.
module aotr_classify
  import aotr_pkg::*;
(
  input  box_t              box_i,
  input  logic [31:0]       x_i,
  input  logic [31:0]       y_i,
  input  logic [31:0]       z_i,
  output logic [CODE_W-1:0] code_o
);

  // bit order from MSB: min x, max x, min y, max y, min z, max z
  always_comb begin
    code_o[5] = fge(box_i.min_x, x_i);
    code_o[4] = fge(x_i, box_i.max_x);
    code_o[3] = fge(box_i.min_y, y_i);
    code_o[2] = fge(y_i, box_i.max_y);
    code_o[1] = fge(box_i.min_z, z_i);
    code_o[0] = fge(z_i, box_i.max_z);
  end

endmodule

@@ sv/aabb_outcode_triangle_reject_core.sv @@
// Top level: outcode store, epoch-tagged visited memory and triangle sequencer.
// Begin, vertex and unknown items, and triangles in a stopped pass, give their beat on done_o
// in the cycle after start. Other triangles go through ST_TRI_B and ST_TRI_C (two code-store
// read turns plus the visited read-modify-write). busy_o is high while a triangle is in work.
// Reset (and every 15th begin, when the visited epoch wraps) runs a clearing pass over all
// 65536 visited entries with busy_o high. Results cannot be stalled by the receiver.
module aabb_outcode_triangle_reject_core
  import aotr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [1:0]           kind_i,
  input  logic [VSLOT_W-1:0]   vertex_slot_i,
  input  logic [31:0]          vertex_x_i,
  input  logic [31:0]          vertex_y_i,
  input  logic [31:0]          vertex_z_i,
  input  logic [VSLOT_W-1:0]   corner_a_i,
  input  logic [VSLOT_W-1:0]   corner_b_i,
  input  logic [VSLOT_W-1:0]   corner_c_i,
  input  logic [15:0]          tri_select_bits_i,
  input  logic [IDX_W-1:0]     tri_index_i,
  input  logic [7:0]           flag_byte_i,
  output logic                 done_o,
  output logic [CODE_W-1:0]    vertex_code_o,
  output logic                 queued_o,
  output logic [HIT_W-1:0]     hit_slot_o,
  output logic                 near_hit_o,
  output logic                 ring_full_o
);

  // configuration registers
  box_t              box_q;
  logic [15:0]       mask_q;
  logic [FILL_W-1:0] fill_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q        <= '0;
      mask_q       <= '0;
      fill_start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MIN_X:      box_q.min_x  <= cfg_data_i;
        REG_MIN_Y:      box_q.min_y  <= cfg_data_i;
        REG_MIN_Z:      box_q.min_z  <= cfg_data_i;
        REG_MAX_X:      box_q.max_x  <= cfg_data_i;
        REG_MAX_Y:      box_q.max_y  <= cfg_data_i;
        REG_MAX_Z:      box_q.max_z  <= cfg_data_i;
        REG_MASK:       mask_q       <= cfg_data_i[15:0];
        REG_FILL_START: fill_start_q <= cfg_data_i[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // vertex classification
  logic [CODE_W-1:0] vcode;

  aotr_classify u_classify (
    .box_i  (box_q),
    .x_i    (vertex_x_i),
    .y_i    (vertex_y_i),
    .z_i    (vertex_z_i),
    .code_o (vcode)
  );

  // outcode store: one write port, two read ports
  logic [CODE_W-1:0]  code_mem [MAX_VERTS];
  logic               code_we;
  logic [VSLOT_W-1:0] code_wa;
  logic [VSLOT_W-1:0] code_ra_a;
  logic [VSLOT_W-1:0] code_ra_b;
  logic [CODE_W-1:0]  code_rd_a;
  logic [CODE_W-1:0]  code_rd_b;

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_wa] <= vcode;
    end
    code_rd_a <= code_mem[code_ra_a];
    code_rd_b <= code_mem[code_ra_b];
  end

  // visited memory holds the epoch in which each index was last queued
  logic [EPOCH_W-1:0] vis_mem [INDEX_SPACE];
  logic               vis_we;
  logic [IDX_W-1:0]   vis_wa;
  logic [EPOCH_W-1:0] vis_wd;
  logic [IDX_W-1:0]   vis_ra;
  logic [EPOCH_W-1:0] vis_rd;

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd <= vis_mem[vis_ra];
  end

  // control state
  state_e             state_q, state_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               stopped_q, stopped_d;
  logic [IDX_W-1:0]   clr_q, clr_d;

  // triangle work registers
  logic [15:0]        sel_q, sel_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [7:0]         flag_q, flag_d;
  logic [VSLOT_W-1:0] corner_c_q, corner_c_d;
  logic [CODE_W-1:0]  ab_q, ab_d;
  logic               seen_q, seen_d;

  // result registers
  logic               done_q, done_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic               queued_q, queued_d;
  logic [HIT_W-1:0]   slot_q, slot_d;
  logic               near_q, near_d;
  logic               full_q, full_d;

  logic               accept;
  logic [7:0]         flag_eff;
  logic               skip;
  logic               ring_is_full;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d    = state_q;
    epoch_d    = epoch_q;
    fill_d     = fill_q;
    stopped_d  = stopped_q;
    clr_d      = clr_q;
    sel_d      = sel_q;
    idx_d      = idx_q;
    flag_d     = flag_q;
    corner_c_d = corner_c_q;
    ab_d       = ab_q;
    seen_d     = seen_q;
    done_d     = 1'b0;
    code_d     = '0;
    queued_d   = 1'b0;
    slot_d     = '0;
    near_d     = 1'b0;
    full_d     = 1'b0;
    code_we    = 1'b0;
    code_wa    = vertex_slot_i;
    code_ra_a  = corner_a_i;
    code_ra_b  = corner_b_i;
    vis_we     = 1'b0;
    vis_wa     = idx_q;
    vis_wd     = epoch_q;
    vis_ra     = tri_index_i;
    flag_eff     = flag_q | (seen_q ? VisitedFlag : 8'h00);
    skip         = ((mask_q & sel_q) != 16'h0) || ((mask_q[7:0] & flag_eff) != 8'h0);
    ring_is_full = (fill_q >= FILL_W'(RING_CAP));

    case (state_q)
      // sweep the visited memory back to epoch zero
      ST_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_q;
        vis_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (kind_e'(kind_i))
            KIND_BEGIN: begin
              fill_d    = fill_start_q;
              stopped_d = 1'b0;
              if (epoch_q == '1) begin
                epoch_d = EPOCH_W'(1);
                state_d = ST_CLEAR;
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
            end
            KIND_VERTEX: begin
              code_we = 1'b1;
              code_d  = vcode;
            end
            KIND_TRI: begin
              if (stopped_q) begin
                full_d = 1'b1;
              end else begin
                done_d     = 1'b0;
                sel_d      = tri_select_bits_i;
                idx_d      = tri_index_i;
                flag_d     = flag_byte_i;
                corner_c_d = corner_c_i;
                state_d    = ST_TRI_B;
              end
            end
            default: ;
          endcase
        end
      end
      // corners a and b are back; fetch c
      ST_TRI_B: begin
        ab_d      = code_rd_a & code_rd_b;
        seen_d    = (vis_rd == epoch_q);
        code_ra_a = corner_c_q;
        state_d   = ST_TRI_C;
      end
      // decide and update visited mark and ring fill
      ST_TRI_C: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (!skip) begin
          if (ring_is_full) begin
            stopped_d = 1'b1;
            full_d    = 1'b1;
          end else begin
            queued_d = 1'b1;
            slot_d   = fill_q[HIT_W-1:0];
            near_d   = ((ab_q & code_rd_a) == '0);
            fill_d   = fill_q + 1'b1;
            vis_we   = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      epoch_q   <= EPOCH_W'(1);
      fill_q    <= '0;
      stopped_q <= 1'b0;
      clr_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      epoch_q   <= epoch_d;
      fill_q    <= fill_d;
      stopped_q <= stopped_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    idx_q      <= idx_d;
    flag_q     <= flag_d;
    corner_c_q <= corner_c_d;
    ab_q       <= ab_d;
    seen_q     <= seen_d;
    code_q     <= code_d;
    queued_q   <= queued_d;
    slot_q     <= slot_d;
    near_q     <= near_d;
    full_q     <= full_d;
  end

  assign done_o        = done_q;
  assign vertex_code_o = code_q;
  assign queued_o      = queued_q;
  assign hit_slot_o    = slot_q;
  assign near_hit_o    = near_q;
  assign ring_full_o   = full_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for the outcode reject core: directed cases, then random phases of begins, vertices, triangles.
module tb
  import aotr_pkg::*;
;

  localparam int CycleLimit = 3_000_000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VSLOT_W-1:0] vslot;
    logic [31:0]        vx;
    logic [31:0]        vy;
    logic [31:0]        vz;
    logic [VSLOT_W-1:0] ca;
    logic [VSLOT_W-1:0] cb;
    logic [VSLOT_W-1:0] cc;
    logic [15:0]        sel;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         flag;
  } work_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              queued;
    logic [HIT_W-1:0]  slot;
    logic              near;
    logic              full;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  work_t cur = '0;
  logic busy_o, done_o, queued_o, near_hit_o, ring_full_o;
  logic [CODE_W-1:0] vertex_code_o;
  logic [HIT_W-1:0] hit_slot_o;

  aabb_outcode_triangle_reject_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i(cur.kind), .vertex_slot_i(cur.vslot),
    .vertex_x_i(cur.vx), .vertex_y_i(cur.vy), .vertex_z_i(cur.vz),
    .corner_a_i(cur.ca), .corner_b_i(cur.cb), .corner_c_i(cur.cc),
    .tri_select_bits_i(cur.sel), .tri_index_i(cur.idx), .flag_byte_i(cur.flag),
    .done_o, .vertex_code_o, .queued_o, .hit_slot_o, .near_hit_o, .ring_full_o
  );

  // Clock: period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic [31:0] bnd [6];
  logic [15:0] qmask;
  logic [FILL_W-1:0] fill_start;
  logic [CODE_W-1:0] code_mem [MAX_VERTS];
  bit visited [INDEX_SPACE];
  int unsigned fill;
  bit stopped;

  work_t pend [$];
  answer_t answers_due [$];
  bit written [MAX_VERTS];
  logic [VSLOT_W-1:0] written_list [$];
  logic [IDX_W-1:0] recent_idx [$];
  int fails = 0;
  int cycles = 0;
  bit took = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  // Ordered float a >= b, NaN gives false
  function automatic bit f_ge(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka, kb;
    if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return 1'b0;
    ka = (a == 32'h8000_0000) ? 32'h0 : a;
    kb = (b == 32'h8000_0000) ? 32'h0 : b;
    ka = ka[31] ? ~ka : (ka | 32'h8000_0000);
    kb = kb[31] ? ~kb : (kb | 32'h8000_0000);
    return ka >= kb;
  endfunction

  function automatic logic [CODE_W-1:0] outcode(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {f_ge(bnd[REG_MIN_X], x), f_ge(x, bnd[REG_MAX_X]),
            f_ge(bnd[REG_MIN_Y], y), f_ge(y, bnd[REG_MAX_Y]),
            f_ge(bnd[REG_MIN_Z], z), f_ge(z, bnd[REG_MAX_Z])};
  endfunction

  // Advances predictor state by one accepted beat and returns its answer
  function automatic answer_t reject_step(work_t w);
    answer_t r;
    logic [7:0] fl;
    r = '0;
    case (kind_e'(w.kind))
      KIND_BEGIN: begin
        foreach (visited[i]) visited[i] = 1'b0;
        fill = fill_start;
        stopped = 1'b0;
      end
      KIND_VERTEX: begin
        r.code = outcode(w.vx, w.vy, w.vz);
        code_mem[w.vslot] = r.code;
      end
      KIND_TRI: begin
        fl = w.flag | (visited[w.idx] ? VisitedFlag : 8'h00);
        if (stopped) begin
          r.full = 1'b1;
        end else if ((qmask & w.sel) == 0 && (qmask[7:0] & fl) == 0) begin
          if (fill >= RING_CAP) begin
            stopped = 1'b1;
            r.full = 1'b1;
          end else begin
            r.queued = 1'b1;
            r.slot = fill[HIT_W-1:0];
            fill++;
            visited[w.idx] = 1'b1;
            r.near = (code_mem[w.ca] & code_mem[w.cb] & code_mem[w.cc]) == 0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: bursts with random gaps, changes at falling edge
  always @(negedge clk_i) begin
    logic go;
    go = took ? 1'b0 : start_i;
    if (!go && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend.size() > 0) begin
        cur <= pend.pop_front();
        go = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      end
    end
    start_i <= go;
  end

  // Monitor: check results, record accepted beats
  always @(posedge clk_i) begin
    answer_t exp_r, got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("tb: FAIL");
      $finish;
    end
    if (done_o) begin
      got = '{vertex_code_o, queued_o, hit_slot_o, near_hit_o, ring_full_o};
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        fails++;
      end else begin
        exp_r = answers_due.pop_front();
        if (got.code !== exp_r.code)
          $display("%0t: vertex_code exp %h got %h", $time, exp_r.code, got.code);
        if (got.queued !== exp_r.queued)
          $display("%0t: queued exp %b got %b", $time, exp_r.queued, got.queued);
        if (got.slot !== exp_r.slot)
          $display("%0t: hit_slot exp %0d got %0d", $time, exp_r.slot, got.slot);
        if (got.near !== exp_r.near)
          $display("%0t: near_hit exp %b got %b", $time, exp_r.near, got.near);
        if (got.full !== exp_r.full)
          $display("%0t: ring_full exp %b got %b", $time, exp_r.full, got.full);
        if (got !== exp_r) fails++;
      end
    end
    took = rst_ni && start_i && !busy_o;
    if (took) answers_due.push_back(reject_step(cur));
  end

  task automatic write_reg(cfg_idx_e r, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == REG_MASK) qmask = v[15:0];
    else if (r == REG_FILL_START) fill_start = v[FILL_W-1:0];
    else bnd[r] = v;
  endtask

  // Last beat must be handed over and answered before the core goes quiet
  task automatic drain();
    wait (pend.size() == 0);
    @(posedge clk_i);
    wait (!start_i && answers_due.size() == 0);
    repeat (6) @(posedge clk_i);
    wait (!busy_o);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'($urandom), 9'h1FF, 22'($urandom)};
      5: return bnd[$urandom_range(0, 5)];
      6: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(122, 131)), 23'($urandom)};
    endcase
  endfunction

  function automatic void add_vertex(logic [VSLOT_W-1:0] s, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z);
    work_t w;
    w = work_t'($urandom);
    w.kind = KIND_VERTEX;
    w.vslot = s; w.vx = x; w.vy = y; w.vz = z;
    w.ca = VSLOT_W'($urandom); w.cb = VSLOT_W'($urandom); w.cc = VSLOT_W'($urandom);
    pend.push_back(w);
    if (!written[s]) begin
      written[s] = 1'b1;
      written_list.push_back(s);
    end
  endfunction

  function automatic void add_tri(logic [IDX_W-1:0] idx, logic [15:0] sel, logic [7:0] fl);
    work_t w;
    w = '0;
    w.kind = KIND_TRI;
    w.vslot = VSLOT_W'($urandom); w.vx = $urandom; w.vy = $urandom; w.vz = $urandom;
    w.ca = written_list[$urandom_range(0, written_list.size() - 1)];
    w.cb = written_list[$urandom_range(0, written_list.size() - 1)];
    w.cc = written_list[$urandom_range(0, written_list.size() - 1)];
    w.sel = sel; w.idx = idx; w.flag = fl;
    pend.push_back(w);
    recent_idx.push_back(idx);
    if (recent_idx.size() > 8) void'(recent_idx.pop_front());
  endfunction

  function automatic void add_plain(kind_e k);
    work_t w;
    w = work_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    w.kind = k;
    pend.push_back(w);
  endfunction

  initial begin
    logic [15:0] m;
    logic [IDX_W-1:0] ix;
    foreach (bnd[i]) bnd[i] = '0;
    qmask = '0; fill_start = '0; fill = 0; stopped = 1'b0;
    foreach (code_mem[i]) code_mem[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);
    wait (!busy_o);

    // Directed: reset box, signed zeros, infinities, NaN, edge slots, revisits, unknown kind
    add_plain(KIND_BEGIN);
    add_vertex('0, 32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000);
    add_vertex('1, 32'h7F80_0000, 32'hFF80_0000, 32'hFFFF_FFFF);
    add_vertex(9'h155, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_0001);
    add_plain(KIND_NONE);
    add_tri(16'h0000, 16'h0000, 8'h00);
    add_tri('1, 16'hFFFF, 8'hFF);
    add_tri(16'h0000, 16'h0000, 8'h00);
    drain();

    write_reg(REG_MASK, 32'h0000_0080);
    write_reg(REG_FILL_START, 32'd8190);
    add_plain(KIND_BEGIN);
    add_tri(16'h1234, 16'h0000, 8'h00);
    add_tri(16'h1234, 16'h0000, 8'h00);
    add_tri(16'h4321, 16'hFFFF, 8'h7F);
    add_tri(16'h0001, 16'h0000, 8'h00);
    add_tri(16'h0002, 16'h0000, 8'h00);
    add_tri(16'h0003, 16'h0000, 8'h00);
    add_plain(KIND_BEGIN);
    add_tri(16'h1234, 16'h0000, 8'h00);
    drain();

    // Random phases
    for (int p = 0; p < 13; p++) begin
      write_reg(REG_MIN_X, (p == 1) ? 32'h0 : (p == 2) ? 32'hFFFF_FFFF : rand_float());
      write_reg(REG_MIN_Y, (p == 1) ? 32'h0
                           : {1'b1, 8'($urandom_range(122, 131)), 23'($urandom)});
      write_reg(REG_MIN_Z, (p == 2) ? 32'h7F80_0000
                           : {1'b1, 8'($urandom_range(122, 131)), 23'($urandom)});
      write_reg(REG_MAX_X, (p == 2) ? 32'hFFFF_FFFF
                           : {1'b0, 8'($urandom_range(122, 131)), 23'($urandom)});
      write_reg(REG_MAX_Y, (p == 1) ? 32'h8000_0000 : rand_float());
      write_reg(REG_MAX_Z, (p == 2) ? 32'hFF80_0000
                           : {1'b0, 8'($urandom_range(122, 131)), 23'($urandom)});
      case (p % 4)
        0: m = 16'h0000;
        1: m = 16'h0080;
        2: m = (16'h1 << $urandom_range(0, 15)) | 16'h0080;
        default: m = (p == 11) ? 16'hFFFF : 16'($urandom) & 16'($urandom) & 16'($urandom);
      endcase
      write_reg(REG_MASK, m);
      case (p % 5)
        0: write_reg(REG_FILL_START, 32'd0);
        1: write_reg(REG_FILL_START, 32'($urandom_range(0, 8191)));
        2: write_reg(REG_FILL_START, 32'($urandom_range(8100, 8191)));
        3: write_reg(REG_FILL_START, 32'd8192);
        default: write_reg(REG_FILL_START, 32'd8191);
      endcase
      add_plain(KIND_BEGIN);
      for (int k = 0; k < 120; k++) begin
        case ($urandom_range(0, 99)) inside
          [0:1]:   add_plain(KIND_BEGIN);
          [2:3]:   add_plain(KIND_NONE);
          [4:38]:  add_vertex(VSLOT_W'($urandom), rand_float(), rand_float(), rand_float());
          default: begin
            ix = (recent_idx.size() > 0 && $urandom_range(0, 3) == 0)
                 ? recent_idx[$urandom_range(0, recent_idx.size() - 1)] : 16'($urandom);
            add_tri(ix, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h0);
          end
        endcase
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/aotr_pkg.sv
sv/aotr_classify.sv
sv/aabb_outcode_triangle_reject_core.sv
tb/sv/tb.sv
